[rtl/event_queue_match_pop_defines.svh]
// Assertion macros for the event queue with match and pop.
`ifndef EVENT_QUEUE_MATCH_POP_DEFINES_SVH
`define EVENT_QUEUE_MATCH_POP_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define EQMP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("%m: check failed");

// Next-cycle implication, checked out of reset.
`define EQMP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

[rtl/eqmp_pkg.sv]
// Package for the event queue: sizes, slot and cell command types, payload clip.
package eqmp_pkg;

  localparam int QUEUE_DEPTH   = 16;
  localparam int PAYLOAD_BYTES = 8;
  localparam int CNT_W         = $clog2(QUEUE_DEPTH + 1);
  localparam int OCC_W         = 5;
  localparam int IN_DATA_W     = 168;
  localparam int IN_USER_W     = 1;
  localparam int OUT_DATA_W    = 136;
  localparam int OUT_USER_W    = 2;

  localparam logic KIND_PUSH  = 1'b0;
  localparam logic KIND_AWAIT = 1'b1;

  typedef struct packed {
    logic [63:0] payload;
    logic [31:0] ev_source;
    logic [31:0] ev_type;
  } slot_t;

  typedef struct packed {
    logic        push;
    logic        pop;
    logic [31:0] topic;
  } cell_cmd_t;

  function automatic logic [63:0] clip_payload(input logic [63:0] bytes_in,
                                               input logic [7:0]  len);
    logic [63:0] res;
    for (int b = 0; b < PAYLOAD_BYTES; b++) begin
      res[8*b +: 8] = (len > 8'(b)) ? bytes_in[8*b +: 8] : 8'h00;
    end
    return res;
  endfunction

endpackage

[rtl/eqmp_cell.sv]
// One queue cell: holds a slot, matches the topic, shifts toward the old end on a pop that matched at or before it.
module eqmp_cell (
  input  logic                 clk_i,
  input  eqmp_pkg::cell_cmd_t  cmd_i,
  input  logic                 occupied_i,
  input  logic                 tail_i,
  input  eqmp_pkg::slot_t      push_slot_i,
  input  eqmp_pkg::slot_t      next_slot_i,
  input  logic                 hit_i,
  input  eqmp_pkg::slot_t      acc_i,
  output eqmp_pkg::slot_t      slot_o,
  output logic                 hit_o,
  output eqmp_pkg::slot_t      acc_o
);
  import eqmp_pkg::*;

  slot_t slot_q, slot_d;
  logic  match, first;

  always_comb begin
    match  = occupied_i & cmd_i.pop & (slot_q.ev_type == cmd_i.topic);
    first  = match & ~hit_i;
    hit_o  = hit_i | match;
    acc_o  = acc_i | (first ? slot_q : slot_t'('0));
    slot_o = slot_q;
    priority if (cmd_i.push && tail_i) begin
      slot_d = push_slot_i;
    end else if (cmd_i.pop && hit_o) begin
      slot_d = next_slot_i;
    end else begin
      slot_d = slot_q;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

endmodule

[rtl/event_queue_match_pop.sv]
// Event queue top level: stream ports, fill count, cell chain, output register.
// The result of each input transfer is registered into the output register.
// Throughput: one item per cycle while results are taken; the cell chain
// matches, selects and collapses the queue in the same cycle as the transfer.
// Reset clears the fill count and the output valid; slot contents are not
// cleared (no clearing pass), slots at or above the fill count never reach the output.
`include "event_queue_match_pop_defines.svh"

module event_queue_match_pop (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // topic, event_type, event_source, event_payload, payload_length
  input  logic [eqmp_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // kind
  input  logic [eqmp_pkg::IN_USER_W-1:0]   s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // matched_type, matched_source, matched_payload, occupancy, zero pad
  output logic [eqmp_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  // found, accepted
  output logic [eqmp_pkg::OUT_USER_W-1:0]  m_axis_tuser
);
  import eqmp_pkg::*;

  logic             in_fire;
  logic             in_kind;
  logic [31:0]      in_topic;
  logic [7:0]       in_len;
  slot_t            push_slot;
  cell_cmd_t        cmd;

  logic [CNT_W-1:0] count_q, count_d;
  logic             full;
  logic             push_ok;

  slot_t            slots     [QUEUE_DEPTH];
  slot_t            next_slot [QUEUE_DEPTH];
  slot_t            acc       [QUEUE_DEPTH+1];
  logic [QUEUE_DEPTH:0] hit;

  logic             out_valid_q;
  logic             found_q, accepted_q;
  slot_t            mslot_q;
  logic [OCC_W-1:0] occ_q;

  assign s_axis_tready = ~out_valid_q | m_axis_tready;
  assign in_fire       = s_axis_tvalid & s_axis_tready;

  assign in_kind             = s_axis_tuser[0];
  assign in_topic            = s_axis_tdata[31:0];
  assign push_slot.ev_type   = s_axis_tdata[63:32];
  assign push_slot.ev_source = s_axis_tdata[95:64];
  assign in_len              = s_axis_tdata[167:160];
  assign push_slot.payload   = clip_payload(s_axis_tdata[159:96], in_len);

  assign cmd.push  = in_fire & (in_kind == KIND_PUSH);
  assign cmd.pop   = in_fire & (in_kind == KIND_AWAIT);
  assign cmd.topic = in_topic;

  assign full    = (count_q == CNT_W'(QUEUE_DEPTH));
  assign push_ok = cmd.push & ~full;

  assign hit[0] = 1'b0;
  assign acc[0] = '0;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign next_slot[i] = '0;
    end else begin : g_mid
      assign next_slot[i] = slots[i+1];
    end

    eqmp_cell u_cell (
      .clk_i       (clk_i),
      .cmd_i       (cmd),
      .occupied_i  (count_q > CNT_W'(i)),
      .tail_i      (count_q == CNT_W'(i)),
      .push_slot_i (push_slot),
      .next_slot_i (next_slot[i]),
      .hit_i       (hit[i]),
      .acc_i       (acc[i]),
      .slot_o      (slots[i]),
      .hit_o       (hit[i+1]),
      .acc_o       (acc[i+1])
    );
  end

  always_comb begin
    count_d = count_q;
    if (push_ok) begin
      count_d = count_q + 1'b1;
    end else if (cmd.pop && hit[QUEUE_DEPTH]) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      found_q    <= cmd.pop & hit[QUEUE_DEPTH];
      accepted_q <= push_ok;
      mslot_q    <= acc[QUEUE_DEPTH];
      occ_q      <= OCC_W'(count_d);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, occ_q, mslot_q.payload, mslot_q.ev_source, mslot_q.ev_type};
  assign m_axis_tuser  = {accepted_q, found_q};

  `EQMP_ASSERT_IMP(a_count_bound, 1'b1, count_q <= CNT_W'(QUEUE_DEPTH))
  `EQMP_ASSERT_NXT(a_push_grows, push_ok, count_q == CNT_W'($past(count_q) + 1'b1))
  `EQMP_ASSERT_IMP(a_flags_excl, out_valid_q, !(found_q && accepted_q))
  `EQMP_ASSERT_NXT(a_match_type, cmd.pop && hit[QUEUE_DEPTH], mslot_q.ev_type == $past(in_topic))

endmodule
